// ----- rtl/lrup_pkg.sv -----
`timescale 1ns / 1ps

package lrup_pkg;

  localparam int CFG_WIDTH = 4;
  localparam logic [CFG_WIDTH-1:0] CFG_RESET = 4'd8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_TRIM   = 5'b00010,
    S_LOOKUP = 5'b00100,
    S_UPDATE = 5'b01000,
    S_EMIT   = 5'b10000
  } back_state_t;

endpackage

// ----- rtl/lrup_front.sv -----
`timescale 1ns / 1ps

module lrup_front import lrup_pkg::*; #(
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [PAGE_BITS-1:0] page,
  output logic                 busy,
  input  logic                 q_pop,
  output logic                 q_valid,
  output logic [PAGE_BITS-1:0] q_page
);

  logic [PAGE_BITS-1:0] mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr;
  logic [QPTR_W-1:0]    rd_ptr;
  logic [QCNT_W-1:0]    count;
  logic                 push;

  assign busy    = (count == QCNT_W'(QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (count != '0);
  assign q_page  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/lrup_back.sv -----
`timescale 1ns / 1ps

module lrup_back import lrup_pkg::*; #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CFG_WIDTH-1:0] frames_in_use,
  input  logic                 q_valid,
  input  logic [PAGE_BITS-1:0] q_page,
  output logic                 q_pop,
  output logic                 result_valid,
  output logic [PAGE_BITS-1:0] slot_page,
  output logic                 slot_valid,
  output logic                 access_hit,
  output logic                 last_slot
);

  localparam int SW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RW = SW;
  localparam int CW = $clog2(FRAMES + 1);

  back_state_t          state;
  logic [PAGE_BITS-1:0] fpage [FRAMES];
  logic                 fvalid [FRAMES];
  logic [RW-1:0]        frank [FRAMES];
  logic [CW-1:0]        fill;
  logic [CW-1:0]        n_r;
  logic [PAGE_BITS-1:0] pg;
  logic [FRAMES-1:0]    match;
  logic                 hit_r;
  logic [RW-1:0]        hit_rank;
  logic [SW-1:0]        s;

  logic [CW-1:0]        n_next;
  logic [SW-1:0]        k;
  logic [RW-1:0]        k_rank;
  logic [FRAMES-1:0]    match_next;
  logic [RW-1:0]        hit_rank_next;
  logic [FRAMES-1:0]    tgt;
  logic [CW-1:0]        thr;
  logic                 room;

  always_comb begin
    if (frames_in_use == '0) begin
      n_next = CW'(1);
    end else if (int'(frames_in_use) > FRAMES) begin
      n_next = CW'(FRAMES);
    end else begin
      n_next = CW'(frames_in_use);
    end
  end

  assign q_pop  = (state == S_IDLE) && q_valid;
  assign k      = SW'(fill - 1'b1);
  assign k_rank = frank[k];
  assign room   = (fill < n_r);

  always_comb begin
    hit_rank_next = '0;
    for (int i = 0; i < FRAMES; i++) begin
      match_next[i] = fvalid[i] && (fpage[i] == pg);
      if (match_next[i]) begin
        hit_rank_next = hit_rank_next | frank[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      if (hit_r) begin
        tgt[i] = match[i];
      end else if (room) begin
        tgt[i] = (CW'(i) == fill);
      end else begin
        tgt[i] = fvalid[i] && (CW'(frank[i]) == n_r - 1'b1);
      end
    end
    if (hit_r) begin
      thr = CW'(hit_rank);
    end else if (room) begin
      thr = fill;
    end else begin
      thr = n_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        fvalid[i] <= 1'b0;
        frank[i]  <= '0;
      end
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            pg  <= q_page;
            n_r <= n_next;
            if (fill > n_next) begin
              state <= S_TRIM;
            end else begin
              state <= S_LOOKUP;
            end
          end
        end
        S_TRIM: begin
          for (int i = 0; i < FRAMES; i++) begin
            if (SW'(i) == k) begin
              fvalid[i] <= 1'b0;
              frank[i]  <= '0;
            end else if (fvalid[i] && (frank[i] > k_rank)) begin
              frank[i] <= frank[i] - 1'b1;
            end
          end
          fill <= fill - 1'b1;
          if (fill - 1'b1 == n_r) begin
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          match    <= match_next;
          hit_r    <= (match_next != '0);
          hit_rank <= hit_rank_next;
          state    <= S_UPDATE;
        end
        S_UPDATE: begin
          for (int i = 0; i < FRAMES; i++) begin
            if (tgt[i]) begin
              fpage[i]  <= pg;
              fvalid[i] <= 1'b1;
              frank[i]  <= '0;
            end else if (fvalid[i] && (CW'(frank[i]) < thr)) begin
              frank[i] <= frank[i] + 1'b1;
            end
          end
          if (!hit_r && room) begin
            fill <= fill + 1'b1;
          end
          s     <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          result_valid <= 1'b1;
          slot_page    <= fvalid[s] ? fpage[s] : '0;
          slot_valid   <= fvalid[s];
          access_hit   <= hit_r;
          last_slot    <= (CW'(s) == n_r - 1'b1);
          if (CW'(s) == n_r - 1'b1) begin
            state <= S_IDLE;
          end else begin
            s <= s + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/lru_page_replacement_core.sv -----
`timescale 1ns / 1ps
// Sequencing: the back-end sequencer takes a request from the queue when idle, drops frames
//   one at a time while more are filled than the lowered frame count allows, then walks
//   lookup, update and one result per frame in use; a 2-entry queue takes requests
//   while the back end works, busy rises only when it is full.
// Reset (rst, synchronous): queue emptied, all frames empty, frames_in_use = 8.

module lru_page_replacement_core import lrup_pkg::*; #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [PAGE_BITS-1:0] page,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_WIDTH-1:0] cfg_data,
  output logic                 result_valid,
  output logic [PAGE_BITS-1:0] slot_page,
  output logic                 slot_valid,
  output logic                 access_hit,
  output logic                 last_slot
);

  logic [CFG_WIDTH-1:0] frames_in_use;
  logic                 q_valid;
  logic                 q_pop;
  logic [PAGE_BITS-1:0] q_page;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frames_in_use <= cfg_data;
    end
  end

  lrup_front #(
    .PAGE_BITS(PAGE_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .page    (page),
    .busy    (busy),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_page  (q_page)
  );

  lrup_back #(
    .FRAMES   (FRAMES),
    .PAGE_BITS(PAGE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .frames_in_use(frames_in_use),
    .q_valid      (q_valid),
    .q_page       (q_page),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .slot_page    (slot_page),
    .slot_valid   (slot_valid),
    .access_hit   (access_hit),
    .last_slot    (last_slot)
  );

endmodule

// ----- rtl/lrup_checker.sv -----
`timescale 1ns / 1ps

module lrup_checker #(
  parameter int PAGE_BITS = 16
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 result_valid,
  input logic [PAGE_BITS-1:0] slot_page,
  input logic                 slot_valid,
  input logic                 access_hit,
  input logic                 last_slot
);

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_slot |=> !result_valid)
    else $error("result right after last slot");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_slot |=> result_valid)
    else $error("result burst broken before last slot");

  a_hit_steady: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_slot |=> $stable(access_hit))
    else $error("hit flag changed within one request");

  a_empty_slot_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !slot_valid |-> slot_page == '0)
    else $error("empty slot shows a page");

endmodule

bind lru_page_replacement_core lrup_checker #(
  .PAGE_BITS(PAGE_BITS)
) u_lrup_checker (
  .clk         (clk),
  .rst         (rst),
  .result_valid(result_valid),
  .slot_page   (slot_page),
  .slot_valid  (slot_valid),
  .access_hit  (access_hit),
  .last_slot   (last_slot)
);
